### sv/apd_pkg.sv
package apd_pkg;

  localparam int unsigned AvgWidth    = 16;
  localparam int unsigned FieldWidth  = 10;
  localparam int unsigned ThrWidth    = 12;
  localparam int unsigned PadWidth    = 6;
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned CfgDatWidth = 16;
  localparam int unsigned InTdataW    = 16;
  localparam int unsigned OutTdataW   = 32;

  localparam logic [AvgWidth-1:0] ResetBias   = 16'd511;
  localparam logic [AvgWidth-1:0] ResetUpper  = 16'd520;
  localparam logic [AvgWidth-1:0] ResetLower  = 16'd500;
  localparam logic [AvgWidth-1:0] AvgOffset   = 16'd8;
  localparam logic [PadWidth-1:0] ResetPad    = 6'd10;
  localparam logic [AvgWidth-1:0] ResetHold   = 16'd200;

  localparam logic [CfgIdxWidth-1:0] RegPadding   = 8'd0;
  localparam logic [CfgIdxWidth-1:0] RegHoldTicks = 8'd1;

  typedef struct packed {
    logic [AvgWidth-1:0] bias_avg;
    logic [AvgWidth-1:0] upper_avg;
    logic [AvgWidth-1:0] lower_avg;
    logic [AvgWidth-1:0] hold_count;
    logic                neg_lit;
    logic                pos_lit;
    logic                relay_on;
  } state_t;

  // Field order from the lowest bit up: neg_led, pos_led, switch_on,
  // low_threshold, high_threshold.
  typedef struct packed {
    logic [ThrWidth-1:0] high_threshold;
    logic [ThrWidth-1:0] low_threshold;
    logic                switch_on;
    logic                pos_led;
    logic                neg_led;
  } result_t;

  localparam int unsigned ResultWidth = $bits(result_t);

  // avg <- x + avg - ((avg - 8) >> 4), all modulo 2^16
  function automatic logic [AvgWidth-1:0] ewma_next(input logic [AvgWidth-1:0] avg,
                                                    input logic [AvgWidth-1:0] x);
    logic [AvgWidth-1:0] decay;
    decay = (avg - AvgOffset) >> 4;
    return (x + avg) - decay;
  endfunction

endpackage

### sv/apd_update.sv
module apd_update (
  input  apd_pkg::state_t                          state_i,
  input  logic [apd_pkg::FieldWidth-1:0]          sample_i,
  input  logic [apd_pkg::PadWidth-1:0]            padding_i,
  input  logic [apd_pkg::AvgWidth-1:0]            hold_ticks_i,
  output apd_pkg::state_t                          state_o,
  output apd_pkg::result_t                         result_o
);

  logic [apd_pkg::AvgWidth-1:0] x;
  logic [apd_pkg::AvgWidth-1:0] bias_n;
  logic [apd_pkg::AvgWidth-1:0] center;
  logic [apd_pkg::AvgWidth-1:0] upper_n;
  logic [apd_pkg::AvgWidth-1:0] lower_n;
  logic [apd_pkg::AvgWidth-1:0] margin;
  logic [apd_pkg::AvgWidth-1:0] lo_sum;
  logic [apd_pkg::AvgWidth-1:0] hi_sum;
  logic [apd_pkg::ThrWidth-1:0] lo_thr;
  logic [apd_pkg::ThrWidth-1:0] hi_thr;
  logic                         below;
  logic                         above;

  assign x      = {{(apd_pkg::AvgWidth - apd_pkg::FieldWidth){1'b0}}, sample_i};
  assign bias_n = apd_pkg::ewma_next(state_i.bias_avg, x);
  assign center = bias_n >> 4;

  assign upper_n = (x > center) ? apd_pkg::ewma_next(state_i.upper_avg, x) : state_i.upper_avg;
  assign lower_n = (x < center) ? apd_pkg::ewma_next(state_i.lower_avg, x) : state_i.lower_avg;

  assign margin = (upper_n - lower_n)
                + {{(apd_pkg::AvgWidth - apd_pkg::PadWidth){1'b0}}, padding_i};
  assign lo_sum    = bias_n - margin;
  assign hi_sum    = bias_n + margin;
  assign lo_thr    = lo_sum[apd_pkg::AvgWidth-1:4];
  assign hi_thr    = hi_sum[apd_pkg::AvgWidth-1:4];

  assign below = x < {{(apd_pkg::AvgWidth - apd_pkg::ThrWidth){1'b0}}, lo_thr};
  assign above = x > {{(apd_pkg::AvgWidth - apd_pkg::ThrWidth){1'b0}}, hi_thr};

  always_comb begin
    state_o           = state_i;
    state_o.bias_avg  = bias_n;
    state_o.upper_avg = upper_n;
    state_o.lower_avg = lower_n;
    // low test wins when wrapped thresholds cross
    priority if (below) begin
      state_o.neg_lit    = 1'b1;
      state_o.pos_lit    = 1'b0;
      state_o.relay_on   = 1'b1;
      state_o.hold_count = hold_ticks_i;
    end else if (above) begin
      state_o.neg_lit    = 1'b0;
      state_o.pos_lit    = 1'b1;
      state_o.relay_on   = 1'b1;
      state_o.hold_count = hold_ticks_i;
    end else if (state_i.hold_count != '0) begin
      state_o.hold_count = state_i.hold_count - 16'd1;
    end else begin
      state_o.neg_lit  = 1'b0;
      state_o.pos_lit  = 1'b0;
      state_o.relay_on = 1'b0;
    end
  end

  always_comb begin
    result_o.neg_led        = state_o.neg_lit;
    result_o.pos_led        = state_o.pos_lit;
    result_o.switch_on      = state_o.relay_on;
    result_o.low_threshold  = lo_thr;
    result_o.high_threshold = hi_thr;
  end

endmodule

### sv/adaptive_peak_detector_hold.sv
// A sample request accepted at one edge is written to the input register,
// then to the result register once that is empty or being read out.
// Throughput: one sample per cycle unless the output stalls; the averages,
// thresholds and hold logic are computed from the registered sample.
// Reset (rst_ni low, asynchronous): averages to 511/520/500, hold counter and
// outputs off, padding to 10, hold_ticks to 200, both stages empty.
module adaptive_peak_detector_hold #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [9:0] sample, upper bits zero
  input  logic [apd_pkg::InTdataW-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] neg_led, [1] pos_led, [2] switch_on, [14:3] low_threshold,
  // [26:15] high_threshold, upper bits zero
  output logic [apd_pkg::OutTdataW-1:0]       m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [apd_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [apd_pkg::CfgDatWidth-1:0]     cfg_data_i
);

  localparam logic [apd_pkg::FieldWidth-1:0] SampleMask =
    (SAMPLE_BITS >= apd_pkg::FieldWidth) ? '1
                                         : apd_pkg::FieldWidth'((1 << SAMPLE_BITS) - 1);

  logic                                 in_valid_q;
  logic [apd_pkg::FieldWidth-1:0]       in_sample_q;
  logic                                 out_valid_q;
  apd_pkg::result_t                     result_q;
  apd_pkg::result_t                     result_d;
  apd_pkg::state_t                      state_q;
  apd_pkg::state_t                      state_d;
  logic [apd_pkg::PadWidth-1:0]         padding_q;
  logic [apd_pkg::AvgWidth-1:0]         hold_ticks_q;
  logic                                 advance;
  logic                                 in_fire;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  apd_update u_update (
    .state_i      (state_q),
    .sample_i     (in_sample_q),
    .padding_i    (padding_q),
    .hold_ticks_i (hold_ticks_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q.bias_avg    <= apd_pkg::ResetBias;
      state_q.upper_avg   <= apd_pkg::ResetUpper;
      state_q.lower_avg   <= apd_pkg::ResetLower;
      state_q.hold_count  <= '0;
      state_q.neg_lit     <= 1'b0;
      state_q.pos_lit     <= 1'b0;
      state_q.relay_on    <= 1'b0;
      padding_q           <= apd_pkg::ResetPad;
      hold_ticks_q        <= apd_pkg::ResetHold;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          apd_pkg::RegPadding:   padding_q    <= cfg_data_i[apd_pkg::PadWidth-1:0];
          apd_pkg::RegHoldTicks: hold_ticks_q <= cfg_data_i;
          default: ; // drop writes to unknown registers
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_sample_q <= s_axis_tdata[apd_pkg::FieldWidth-1:0] & SampleMask;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(apd_pkg::OutTdataW - apd_pkg::ResultWidth){1'b0}}, result_q};

  a_leds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.neg_lit && state_q.pos_lit))
    else $error("both LEDs lit");

  a_led_needs_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.neg_lit || state_q.pos_lit) |-> state_q.relay_on)
    else $error("LED lit with relay off");

  a_hold_needs_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.hold_count != '0) |-> state_q.relay_on)
    else $error("hold counter running with relay off");

  a_stall_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |=> (in_valid_q && out_valid_q))
    else $error("item lost under output stall");

  a_state_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a processed sample");

endmodule

### dv/adaptive_peak_detector_hold_test.sv
`timescale 1ns / 1ps

module adaptive_peak_detector_hold_test;

  localparam int unsigned SampleBits = apd_pkg::FieldWidth;
  // Index that maps to no register; writes to it must be dropped.
  localparam logic [apd_pkg::CfgIdxWidth-1:0] RegUnmapped = 8'd7;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [apd_pkg::InTdataW-1:0]    s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [apd_pkg::OutTdataW-1:0]   m_axis_tdata;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [apd_pkg::CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [apd_pkg::CfgDatWidth-1:0] cfg_data_i = '0;

  // Detector shadow state and register copies
  logic [apd_pkg::AvgWidth-1:0] bias_acc  = apd_pkg::ResetBias;
  logic [apd_pkg::AvgWidth-1:0] upper_acc = apd_pkg::ResetUpper;
  logic [apd_pkg::AvgWidth-1:0] lower_acc = apd_pkg::ResetLower;
  logic [apd_pkg::AvgWidth-1:0] hold_left = '0;
  logic                         neg_on    = 1'b0;
  logic                         pos_on    = 1'b0;
  logic                         relay_on  = 1'b0;
  logic [apd_pkg::PadWidth-1:0] pad_cfg   = apd_pkg::ResetPad;
  logic [apd_pkg::AvgWidth-1:0] hold_cfg  = apd_pkg::ResetHold;

  logic [SampleBits-1:0] sample_queue[$];
  apd_pkg::result_t      expected_results[$];
  apd_pkg::result_t      seen_result;
  apd_pkg::result_t      want_result;
  bit                    sample_taken = 1'b0;
  bit                    quiet_flow = 1'b1;
  bit                    drain_hold = 1'b0;
  int unsigned           send_gap = 0;
  int unsigned           stall_left = 0;
  int unsigned           sent_count = 0;
  int unsigned           error_count = 0;

  adaptive_peak_detector_hold #(
    .SAMPLE_BITS(SampleBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // avg + x - ((avg - offset) >> 4), wrapping at 16 bits
  function automatic logic [apd_pkg::AvgWidth-1:0] smooth(
    input logic [apd_pkg::AvgWidth-1:0] avg,
    input logic [apd_pkg::AvgWidth-1:0] x);
    logic [apd_pkg::AvgWidth-1:0] leak;
    logic [apd_pkg::AvgWidth-1:0] sum;
    leak = avg - apd_pkg::AvgOffset;
    leak = leak >> 4;
    sum  = x + avg;
    return sum - leak;
  endfunction

  function automatic apd_pkg::result_t track_sample(input logic [SampleBits-1:0] smp);
    logic [apd_pkg::AvgWidth-1:0] x;
    logic [apd_pkg::AvgWidth-1:0] center;
    logic [apd_pkg::AvgWidth-1:0] margin;
    logic [apd_pkg::AvgWidth-1:0] lo_sum;
    logic [apd_pkg::AvgWidth-1:0] hi_sum;
    logic [apd_pkg::AvgWidth-1:0] lo_thr;
    logic [apd_pkg::AvgWidth-1:0] hi_thr;
    apd_pkg::result_t             res;
    x        = apd_pkg::AvgWidth'(smp);
    bias_acc = smooth(bias_acc, x);
    center   = bias_acc >> 4;
    if (x > center) begin
      upper_acc = smooth(upper_acc, x);
    end
    if (x < center) begin
      lower_acc = smooth(lower_acc, x);
    end
    margin    = upper_acc - lower_acc;
    margin    = margin + apd_pkg::AvgWidth'(pad_cfg);
    lo_sum    = bias_acc - margin;
    hi_sum    = bias_acc + margin;
    lo_thr    = lo_sum >> 4;
    hi_thr    = hi_sum >> 4;
    // Low test wins when wrapping inverts the thresholds
    if (x < lo_thr) begin
      neg_on    = 1'b1;
      pos_on    = 1'b0;
      relay_on  = 1'b1;
      hold_left = hold_cfg;
    end else if (x > hi_thr) begin
      neg_on    = 1'b0;
      pos_on    = 1'b1;
      relay_on  = 1'b1;
      hold_left = hold_cfg;
    end else if (hold_left != '0) begin
      hold_left = hold_left - 16'd1;
    end else begin
      neg_on   = 1'b0;
      pos_on   = 1'b0;
      relay_on = 1'b0;
    end
    res.neg_led        = neg_on;
    res.pos_led        = pos_on;
    res.switch_on      = relay_on;
    res.low_threshold  = lo_thr[apd_pkg::ThrWidth-1:0];
    res.high_threshold = hi_thr[apd_pkg::ThrWidth-1:0];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_flow) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic compare_field(input string label, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  // Accept sample requests and predict their results
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(track_sample(s_axis_tdata[SampleBits-1:0]));
      sample_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || sample_taken) begin
      sample_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (drain_hold && expected_results.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        drain_hold = 1'b0;
        s_axis_tdata  <= apd_pkg::InTdataW'(sample_queue.pop_front());
        s_axis_tvalid <= 1'b1;
        send_gap = pick_gap();
        sent_count++;
        // Hold off now and then until the pipeline has drained
        if ($urandom_range(0, 63) == 0 || sent_count == 400) begin
          drain_hold = 1'b1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result = apd_pkg::result_t'(m_axis_tdata[apd_pkg::ResultWidth-1:0]);
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual 0x%0h", $time,
                 m_axis_tdata);
      end else begin
        want_result = expected_results.pop_front();
        compare_field("neg_led", 32'(want_result.neg_led), 32'(seen_result.neg_led));
        compare_field("pos_led", 32'(want_result.pos_led), 32'(seen_result.pos_led));
        compare_field("switch_on", 32'(want_result.switch_on),
                      32'(seen_result.switch_on));
        compare_field("low_threshold", 32'(want_result.low_threshold),
                      32'(seen_result.low_threshold));
        compare_field("high_threshold", 32'(want_result.high_threshold),
                      32'(seen_result.high_threshold));
      end
    end
  end

  task automatic wait_drained();
    while (sample_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [apd_pkg::CfgIdxWidth-1:0] idx,
                           input logic [apd_pkg::CfgDatWidth-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      apd_pkg::RegPadding: begin
        pad_cfg = value[apd_pkg::PadWidth-1:0];
      end
      apd_pkg::RegHoldTicks: begin
        hold_cfg = value;
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Runs of a level with some jitter, a few spikes, and stretches of pure noise
  task automatic queue_random_samples(input int unsigned count);
    int unsigned queued;
    int unsigned run;
    int unsigned step;
    int          level;
    int          spread;
    int          value;
    bit          noisy;
    queued = 0;
    while (queued < count) begin
      run    = $urandom_range(1, 60);
      level  = $urandom_range(0, 1023);
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
      noisy  = ($urandom_range(0, 9) < 2);
      for (step = 0; step < run && queued < count; step++) begin
        if (noisy) begin
          value = $urandom_range(0, 1023);
        end else begin
          value = $urandom_range(0, 2 * spread);
          value = value + level - spread;
          if (value < 0) begin
            value = 0;
          end else if (value > 1023) begin
            value = 1023;
          end
          if ($urandom_range(0, 31) == 0) begin
            value = $urandom_range(0, 1) ? 1023 : 0;
          end
        end
        sample_queue.push_back(SampleBits'(value));
        queued++;
      end
    end
  endtask

  task automatic run_phase(input logic [apd_pkg::CfgDatWidth-1:0] pad,
                           input logic [apd_pkg::CfgDatWidth-1:0] hold,
                           input int unsigned count, input bit quiet);
    wait_drained();
    write_reg(apd_pkg::RegPadding, pad);
    write_reg(apd_pkg::RegHoldTicks, hold);
    quiet_flow = quiet;
    queue_random_samples(count);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // First sample 32 lands exactly on the center, the updated bias >> 4
    quiet_flow = 1'b0;
    sample_queue = '{10'd32, 10'd0, 10'd1023, 10'd341, 10'd682, 10'd1, 10'd512,
                     10'd1022, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023,
                     10'd511, 10'd510, 10'd16, 10'd500};
    wait_drained();
    // Zero hold: a quiet sample right after a detection turns the outputs off
    write_reg(apd_pkg::RegHoldTicks, 16'd0);
    sample_queue = '{10'd0, 10'd40, 10'd1023, 10'd40, 10'd40};

    run_phase(16'd0, 16'd0, 150, 1'b0);
    run_phase(16'd63, 16'hFFFF, 120, 1'b1);
    run_phase(apd_pkg::CfgDatWidth'($urandom_range(0, 63)),
              apd_pkg::CfgDatWidth'($urandom_range(1, 10)), 200, 1'b0);
    wait_drained();
    write_reg(RegUnmapped, 16'hFFFF);
    run_phase(16'd10, 16'd200, 150, 1'b0);
    run_phase(apd_pkg::CfgDatWidth'($urandom_range(0, 63)),
              apd_pkg::CfgDatWidth'($urandom_range(0, 40)), 180, 1'b1);
    run_phase(apd_pkg::CfgDatWidth'($urandom_range(0, 63)),
              apd_pkg::CfgDatWidth'($urandom_range(0, 65535)), 150, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("adaptive_peak_detector_hold_test: PASS");
    end else begin
      $display("adaptive_peak_detector_hold_test: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("adaptive_peak_detector_hold_test: FAIL");
    $finish;
  end

endmodule

### sim.f
sv/apd_pkg.sv
sv/apd_update.sv
sv/adaptive_peak_detector_hold.sv
dv/adaptive_peak_detector_hold_test.sv
